// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// If pre holds at one edge, post must hold at the next
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/ecc_pkg.sv =====
// Types and constants for the elevator car controller
`default_nettype none
package ecc_pkg;
	localparam int MAX_RIDERS  = 16;
	localparam int FLOOR_COUNT = 64;
	localparam int FLOOR_W     = 6;
	localparam int CNT_W       = $clog2(MAX_RIDERS + 1);
	localparam int IDX_W       = $clog2(MAX_RIDERS);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 6;

	localparam logic [FLOOR_W-1:0] FLOOR_MAX   = FLOOR_W'(FLOOR_COUNT - 1);
	localparam logic [FLOOR_W-1:0] TOP_RESET   = FLOOR_W'(15);
	localparam logic [CNT_W-1:0]   CAP_RESET   = CNT_W'(10);
	localparam logic [CNT_W-1:0]   CAP_MAX     = CNT_W'(MAX_RIDERS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_FLOOR   = 2'd0,
		REG_START_FLOOR = 2'd1,
		REG_CAPACITY    = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_SAME = 2'd2,
		STAT_HIGH = 2'd3
	} status_t;

	typedef enum logic {
		KIND_BOARD = 1'b0,
		KIND_MOVE  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [FLOOR_W-1:0] dest_floor;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [FLOOR_W-1:0] car_position;
		logic               heading_up;
		logic [CNT_W-1:0]   rider_count;
		logic [CNT_W-1:0]   alighted;
		logic [FLOOR_W-1:0] target_floor;
		logic               target_valid;
	} result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/elevator_car_controller_core.sv =====
// Elevator car controller: rider slots scanned by one shared compare unit
//
//  channel | signals                                   | transaction
//  --------+-------------------------------------------+-----------------------------
//  command | start, busy, cmd                          | start && !busy
//  result  | done, result                              | done high for one cycle
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// Board goes straight to done. Move: scan pass if the heading is rechecked,
// then step, drop pass; each pass feeds every slot to the shared comparator.
// Reset clears all control state and every rider valid bit at once.
// Results cannot stall; done pulses the cycle after a board start or last pass.
// Config writes are held off while busy.
`default_nettype none
module elevator_car_controller_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  ecc_pkg::cmd_t                 cmd,
	output logic                          done,
	output ecc_pkg::result_t              result,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [ecc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [ecc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ecc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_STEP = 5'b00100,
		S_DROP = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [FLOOR_W-1:0]     top_q;
	logic [CNT_W-1:0]       cap_q;
	logic [FLOOR_W-1:0]     car_q;
	logic                   up_q;
	logic [FLOOR_W-1:0]     rev_floor_q;
	logic                   rev_valid_q;
	logic [MAX_RIDERS-1:0]  valid_q;
	logic [FLOOR_W-1:0]     floors_q [MAX_RIDERS];
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       idx_q;
	logic [CNT_W-1:0]       above_q;
	logic [CNT_W-1:0]       below_q;
	logic [FLOOR_W-1:0]     lo_q;
	logic [FLOOR_W-1:0]     hi_q;
	logic                   any_q;
	logic                   scan_q;
	logic [CNT_W-1:0]       left_q;
	status_t                status_q;

	logic [FLOOR_W-1:0]     top_eff;
	logic [CNT_W-1:0]       cap_eff;
	logic [IDX_W-1:0]       free_idx;
	logic                   slot_v;
	logic [FLOOR_W-1:0]     slot_f;
	logic                   slot_gt;
	logic                   slot_lt;
	logic                   last_idx;
	logic                   head_new;
	status_t                board_stat;
	reg_idx_t               wr_idx;

	assign top_eff  = (top_q > FLOOR_MAX) ? FLOOR_MAX : top_q;
	assign cap_eff  = (cap_q > CAP_MAX) ? CAP_MAX : cap_q;
	assign busy     = !state_q[0];
	assign done     = (state_q == S_DONE);
	assign cfg_ready = !busy;
	assign wr_idx   = reg_idx_t'(cfg_index);

	// shared compare unit on the slot under the scan index
	assign slot_v   = valid_q[idx_q];
	assign slot_f   = floors_q[idx_q];
	assign slot_gt  = slot_f > car_q;
	assign slot_lt  = slot_f < car_q;
	assign last_idx = (idx_q == IDX_W'(MAX_RIDERS - 1));

	always_comb begin
		free_idx = '0;
		for (int i = MAX_RIDERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IDX_W'(i);
		end
	end

	always_comb begin
		priority if (cnt_q >= cap_eff) begin
			board_stat = STAT_FULL;
		end else if (cmd.dest_floor == car_q) begin
			board_stat = STAT_SAME;
		end else if (cmd.dest_floor > top_eff) begin
			board_stat = STAT_HIGH;
		end else begin
			board_stat = STAT_OK;
		end
	end

	always_comb begin
		priority if (!scan_q) begin
			head_new = up_q;
		end else if (above_q > below_q) begin
			head_new = 1'b1;
		end else if (below_q > above_q) begin
			head_new = 1'b0;
		end else begin
			head_new = up_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && cmd.kind == KIND_BOARD && board_stat == STAT_OK) begin
			floors_q[free_idx] <= cmd.dest_floor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= TOP_RESET;
			cap_q       <= CAP_RESET;
			car_q       <= '0;
			up_q        <= 1'b1;
			rev_floor_q <= '0;
			rev_valid_q <= 1'b0;
			valid_q     <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			above_q     <= '0;
			below_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			any_q       <= 1'b0;
			scan_q      <= 1'b0;
			left_q      <= '0;
			status_q    <= STAT_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (wr_idx)
					REG_TOP_FLOOR: top_q <= cfg_data[FLOOR_W-1:0];
					REG_START_FLOOR: begin
						car_q <= (cfg_data[FLOOR_W-1:0] > FLOOR_MAX) ? FLOOR_MAX
						         : cfg_data[FLOOR_W-1:0];
					end
					REG_CAPACITY: cap_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q  <= '0;
						left_q <= '0;
						if (cmd.kind == KIND_BOARD) begin
							status_q <= board_stat;
							if (board_stat == STAT_OK) begin
								valid_q[free_idx] <= 1'b1;
								cnt_q             <= cnt_q + CNT_W'(1);
							end
							state_q <= S_DONE;
						end else begin
							status_q <= STAT_OK;
							above_q  <= '0;
							below_q  <= '0;
							any_q    <= 1'b0;
							if (!rev_valid_q || rev_floor_q == car_q) begin
								scan_q  <= 1'b1;
								state_q <= S_SCAN;
							end else begin
								scan_q  <= 1'b0;
								state_q <= S_STEP;
							end
						end
					end
				end
				S_SCAN: begin
					if (slot_v) begin
						if (slot_gt) above_q <= above_q + CNT_W'(1);
						if (slot_lt) below_q <= below_q + CNT_W'(1);
						any_q <= 1'b1;
						if (!any_q || slot_f < lo_q) lo_q <= slot_f;
						if (!any_q || slot_f > hi_q) hi_q <= slot_f;
					end
					idx_q <= idx_q + IDX_W'(1);
					if (last_idx) state_q <= S_STEP;
				end
				S_STEP: begin
					if (scan_q) begin
						rev_valid_q <= any_q;
						rev_floor_q <= !any_q ? '0 : (head_new ? hi_q : lo_q);
					end
					if (head_new) begin
						if (car_q >= top_eff) begin
							up_q <= 1'b0;
							if (car_q != '0) car_q <= car_q - FLOOR_W'(1);
						end else begin
							up_q  <= 1'b1;
							car_q <= car_q + FLOOR_W'(1);
						end
					end else begin
						if (car_q == '0) begin
							up_q <= 1'b1;
							if (top_eff != '0) car_q <= FLOOR_W'(1);
						end else begin
							up_q  <= 1'b0;
							car_q <= car_q - FLOOR_W'(1);
						end
					end
					idx_q   <= '0;
					state_q <= S_DROP;
				end
				S_DROP: begin
					if (slot_v && !slot_gt && !slot_lt) begin
						valid_q[idx_q] <= 1'b0;
						left_q         <= left_q + CNT_W'(1);
						cnt_q          <= cnt_q - CNT_W'(1);
					end
					idx_q <= idx_q + IDX_W'(1);
					if (last_idx) state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		result.status       = status_q;
		result.car_position = car_q;
		result.heading_up   = up_q;
		result.rider_count  = cnt_q;
		result.alighted     = left_q;
		result.target_floor = rev_floor_q;
		result.target_valid = rev_valid_q;
	end

`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_cnt_matches, clk, arst_n, cnt_q == CNT_W'($countones(valid_q)), "rider count out of step with valid bits")
	`ASSERT_ALWAYS(a_cnt_cap, clk, arst_n, cnt_q <= CAP_MAX, "rider count above slot count")
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done && !busy, "done held or busy after result")
	`ASSERT_ALWAYS(a_no_target, clk, arst_n, rev_valid_q || rev_floor_q == '0, "target floor set without valid")

endmodule
`default_nettype wire
